>>> src/pcmc_pkg.sv
// ---------------------------------------------------------------------------
// pcmc_pkg
// Shared types, widths and helpers for the point cloud mean centering core.
// ---------------------------------------------------------------------------
`default_nettype none

package pcmc_pkg;

  localparam int COORD_W    = 32;
  localparam int SUM_W      = 48;
  localparam int CNT_W      = 17;
  localparam int MAX_POINTS = 65536;
  localparam int CNT_MAX    = 131071;
  localparam int CNT_LIMIT  = (MAX_POINTS < CNT_MAX) ? MAX_POINTS : CNT_MAX;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int LANES      = 3;

  localparam logic [SUM_W-1:0] POS_LIM = SUM_W'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'(64'd1 << (COORD_W - 1));
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic CMD_ACCUM  = 1'b0;
  localparam logic CMD_CENTER = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_POINT  = 1'b1;

  typedef enum logic [1:0] {
    S_RUN,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic acc_en;     // pass-one item accepted
    logic cap_last;   // pass-one last item accepted
    logic cent_load;  // pass-two item accepted, load centered result
    logic div_load;
    logic div_step;
    logic rpt_load;   // store means, clear sums, load report
  } ctrl_t;

  typedef struct packed {
    logic div_last;
  } stat_t;

  typedef struct packed {
    logic               result_kind;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [COORD_W-1:0] out_z;
    logic               out_point_valid;
    logic               out_last;
    logic [COORD_W-1:0] mean_x;
    logic [COORD_W-1:0] mean_y;
    logic [COORD_W-1:0] mean_z;
    logic               no_valid_points;
  } res_t;

  // Apply sign to a quotient magnitude and clamp to the coordinate range.
  function automatic logic [COORD_W-1:0] sat_quot(input logic neg,
                                                 input logic [SUM_W-1:0] q);
    logic [SUM_W-1:0] nq;
    nq = ~q + SUM_W'(1);
    if (neg) begin
      sat_quot = (q > NEG_LIM) ? COORD_MIN : nq[COORD_W-1:0];
    end else begin
      sat_quot = (q > POS_LIM) ? COORD_MAX : q[COORD_W-1:0];
    end
  endfunction

  // Coordinate minus mean, clamped to the coordinate range.
  function automatic logic [COORD_W-1:0] sat_diff(input logic [COORD_W-1:0] c,
                                                 input logic [COORD_W-1:0] m);
    logic [COORD_W:0] d;
    d = {c[COORD_W-1], c} - {m[COORD_W-1], m};
    if (d[COORD_W] != d[COORD_W-1]) begin
      sat_diff = d[COORD_W] ? COORD_MIN : COORD_MAX;
    end else begin
      sat_diff = d[COORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> src/pcmc_in_if.sv
// ---------------------------------------------------------------------------
// pcmc_in_if
// Point input channel: valid/ready handshake with one point per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface pcmc_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic signed [pcmc_pkg::COORD_W-1:0] coord_x;
  logic signed [pcmc_pkg::COORD_W-1:0] coord_y;
  logic signed [pcmc_pkg::COORD_W-1:0] coord_z;
  logic                             point_valid;
  logic                             last_point;

  modport source (output valid, cmd, coord_x, coord_y, coord_z, point_valid,
                  last_point, input ready);
  modport sink   (input valid, cmd, coord_x, coord_y, coord_z, point_valid,
                  last_point, output ready);
endinterface

`default_nettype wire

>>> src/pcmc_out_if.sv
// ---------------------------------------------------------------------------
// pcmc_out_if
// Result channel: valid/ready handshake carrying reports and centered points.
// ---------------------------------------------------------------------------
`default_nettype none

interface pcmc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                result_kind;
  logic signed [pcmc_pkg::COORD_W-1:0] out_x;
  logic signed [pcmc_pkg::COORD_W-1:0] out_y;
  logic signed [pcmc_pkg::COORD_W-1:0] out_z;
  logic                                out_point_valid;
  logic                                out_last;
  logic signed [pcmc_pkg::COORD_W-1:0] mean_x;
  logic signed [pcmc_pkg::COORD_W-1:0] mean_y;
  logic signed [pcmc_pkg::COORD_W-1:0] mean_z;
  logic                                no_valid_points;

  modport source (output valid, result_kind, out_x, out_y, out_z, out_point_valid,
                  out_last, mean_x, mean_y, mean_z, no_valid_points, input ready);
  modport sink   (input valid, result_kind, out_x, out_y, out_z, out_point_valid,
                  out_last, mean_x, mean_y, mean_z, no_valid_points, output ready);
endinterface

`default_nettype wire

>>> src/pcmc_ctrl.sv
// ---------------------------------------------------------------------------
// pcmc_ctrl
// Sequencer: handshakes, divide sequencing and the output valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module pcmc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_cmd,
  input  wire logic            in_last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire pcmc_pkg::stat_t stat,
  output pcmc_pkg::ctrl_t      ctrl
);

  pcmc_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;
  logic             fire;

  // output register is free if empty or draining this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == pcmc_pkg::S_RUN) && slot_free;
  assign fire      = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcmc_pkg::S_RUN: begin
        if (fire && (in_cmd == pcmc_pkg::CMD_ACCUM) && in_last) begin
          state_nxt = pcmc_pkg::S_LOAD;
        end
      end
      pcmc_pkg::S_LOAD: begin
        state_nxt = pcmc_pkg::S_DIV;
      end
      pcmc_pkg::S_DIV: begin
        if (stat.div_last) begin
          state_nxt = pcmc_pkg::S_DONE;
        end
      end
      pcmc_pkg::S_DONE: begin
        if (slot_free) begin
          state_nxt = pcmc_pkg::S_RUN;
        end
      end
      default: state_nxt = pcmc_pkg::S_RUN;
    endcase
  end

  always_comb begin
    ctrl           = '0;
    ctrl.acc_en    = fire && (in_cmd == pcmc_pkg::CMD_ACCUM);
    ctrl.cap_last  = fire && (in_cmd == pcmc_pkg::CMD_ACCUM) && in_last;
    ctrl.cent_load = fire && (in_cmd == pcmc_pkg::CMD_CENTER);
    ctrl.div_load  = (state_r == pcmc_pkg::S_LOAD);
    ctrl.div_step  = (state_r == pcmc_pkg::S_DIV);
    ctrl.rpt_load  = (state_r == pcmc_pkg::S_DONE) && slot_free;
  end

  always_comb begin
    if (ctrl.cent_load || ctrl.rpt_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcmc_pkg::S_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/pcmc_dp.sv
// ---------------------------------------------------------------------------
// pcmc_dp
// Datapath: sums and count, three-lane restoring divider, stored means,
// centering subtractors and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module pcmc_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire pcmc_pkg::ctrl_t              ctrl,
  output pcmc_pkg::stat_t                   stat,
  input  wire logic [pcmc_pkg::COORD_W-1:0] in_x,
  input  wire logic [pcmc_pkg::COORD_W-1:0] in_y,
  input  wire logic [pcmc_pkg::COORD_W-1:0] in_z,
  input  wire logic                         in_pv,
  input  wire logic                         in_last,
  output pcmc_pkg::res_t                    res
);

  localparam int CW = pcmc_pkg::COORD_W;
  localparam int SW = pcmc_pkg::SUM_W;
  localparam int NW = pcmc_pkg::CNT_W;
  localparam int TW = pcmc_pkg::STEP_W;
  localparam int NL = pcmc_pkg::LANES;

  logic [CW-1:0] coord [NL];

  logic [SW-1:0] sum_r  [NL];
  logic [SW-1:0] sum_nxt[NL];
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] mean_r  [NL];
  logic [CW-1:0] mean_nxt[NL];

  logic [SW-1:0] q_r    [NL];
  logic [SW-1:0] q_nxt  [NL];
  logic [NW-1:0] rem_r  [NL];
  logic [NW-1:0] rem_nxt[NL];
  logic [NW:0]   trial  [NL];
  logic          ge     [NL];
  logic          neg_r  [NL];
  logic [TW-1:0] step_r, step_nxt;
  logic          pv_r;

  logic          acc_ok;
  logic          none;
  logic [CW-1:0] cent [NL];

  pcmc_pkg::res_t res_r, res_nxt;

  assign coord[0] = in_x;
  assign coord[1] = in_y;
  assign coord[2] = in_z;

  assign acc_ok = ctrl.acc_en && in_pv && (cnt_r < NW'(pcmc_pkg::CNT_LIMIT));
  assign none   = (cnt_r == '0);
  assign stat.div_last = (step_r == TW'(SW - 1));

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      // one restoring step: shift in next dividend bit, subtract if it fits
      trial[i]   = {rem_r[i], q_r[i][SW-1]};
      ge[i]      = (trial[i] >= {1'b0, cnt_r});
      rem_nxt[i] = ge[i] ? NW'(trial[i] - {1'b0, cnt_r}) : trial[i][NW-1:0];
      q_nxt[i]   = {q_r[i][SW-2:0], ge[i]};
      sum_nxt[i] = sum_r[i];
      mean_nxt[i] = mean_r[i];
      cent[i]    = pcmc_pkg::sat_diff(coord[i], mean_r[i]);
      if (ctrl.rpt_load) begin
        sum_nxt[i]  = '0;
        mean_nxt[i] = none ? '0 : pcmc_pkg::sat_quot(neg_r[i], q_r[i]);
      end else if (acc_ok) begin
        sum_nxt[i] = sum_r[i] + {{(SW-CW){coord[i][CW-1]}}, coord[i]};
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.rpt_load) begin
      cnt_nxt = '0;
    end else if (acc_ok) begin
      cnt_nxt = cnt_r + NW'(1);
    end
    step_nxt = ctrl.div_load ? '0 : (step_r + TW'(1));
  end

  always_comb begin
    res_nxt = res_r;
    if (ctrl.cent_load) begin
      res_nxt.result_kind     = pcmc_pkg::KIND_POINT;
      res_nxt.out_x           = in_pv ? cent[0] : in_x;
      res_nxt.out_y           = in_pv ? cent[1] : in_y;
      res_nxt.out_z           = in_pv ? cent[2] : in_z;
      res_nxt.out_point_valid = in_pv;
      res_nxt.out_last        = in_last;
      res_nxt.mean_x          = mean_r[0];
      res_nxt.mean_y          = mean_r[1];
      res_nxt.mean_z          = mean_r[2];
      res_nxt.no_valid_points = 1'b0;
    end else if (ctrl.rpt_load) begin
      res_nxt.result_kind     = pcmc_pkg::KIND_REPORT;
      res_nxt.out_x           = '0;
      res_nxt.out_y           = '0;
      res_nxt.out_z           = '0;
      res_nxt.out_point_valid = pv_r;
      res_nxt.out_last        = 1'b1;
      res_nxt.mean_x          = mean_nxt[0];
      res_nxt.mean_y          = mean_nxt[1];
      res_nxt.mean_z          = mean_nxt[2];
      res_nxt.no_valid_points = none;
    end
  end

  assign res = res_r;

  // model state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int i = 0; i < NL; i++) begin
        sum_r[i]  <= '0;
        mean_r[i] <= '0;
      end
    end else begin
      cnt_r <= cnt_nxt;
      for (int i = 0; i < NL; i++) begin
        sum_r[i]  <= sum_nxt[i];
        mean_r[i] <= mean_nxt[i];
      end
    end
  end

  // divider and output payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (ctrl.cap_last) begin
      pv_r <= in_pv;
    end
    if (ctrl.div_load || ctrl.div_step) begin
      step_r <= step_nxt;
    end
    for (int i = 0; i < NL; i++) begin
      if (ctrl.div_load) begin
        neg_r[i] <= sum_r[i][SW-1];
        q_r[i]   <= sum_r[i][SW-1] ? (~sum_r[i] + SW'(1)) : sum_r[i];
        rem_r[i] <= '0;
      end else if (ctrl.div_step) begin
        q_r[i]   <= q_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
    end
  end

endmodule

`default_nettype wire

>>> src/point_cloud_mean_centering_core.sv
// ---------------------------------------------------------------------------
// point_cloud_mean_centering_core
// Two-pass centroid subtraction for a 3D fixed point cloud.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : points (cmd, x, y, z, point_valid, last_point), valid/ready.
//   out_ch : results, valid/ready, behind a single output register.
//   Pass one (cmd 0) items are summed (point_valid only, up to 65536 points)
//   at one per cycle while no held result waits on out_ch.ready, and give no
//   result, except the last_point item, which starts the mean division. The
//   three means come from three restoring dividers running side by side, one
//   quotient bit per cycle over the 48-bit sums, and in_ch.ready stays low
//   until the report is loaded into the output register.
//   Pass two (cmd 1) items give a centered point in the cycle after accept,
//   at one item per cycle while out_ch.ready stays high.
//   When out_ch.ready is low and a result is held, in_ch.ready drops until
//   the held result is taken; no result is dropped.
//   Reset (rst_n low, synchronous) clears sums, count and stored means to
//   zero and empties the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module point_cloud_mean_centering_core (
  input  wire logic clk,
  input  wire logic rst_n,
  pcmc_in_if.sink   in_ch,
  pcmc_out_if.source out_ch
);

  pcmc_pkg::ctrl_t ctrl;
  pcmc_pkg::stat_t stat;
  pcmc_pkg::res_t  res;

  pcmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_last   (in_ch.last_point),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  pcmc_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .stat    (stat),
    .in_x    (in_ch.coord_x),
    .in_y    (in_ch.coord_y),
    .in_z    (in_ch.coord_z),
    .in_pv   (in_ch.point_valid),
    .in_last (in_ch.last_point),
    .res     (res)
  );

  assign out_ch.result_kind     = res.result_kind;
  assign out_ch.out_x           = res.out_x;
  assign out_ch.out_y           = res.out_y;
  assign out_ch.out_z           = res.out_z;
  assign out_ch.out_point_valid = res.out_point_valid;
  assign out_ch.out_last        = res.out_last;
  assign out_ch.mean_x          = res.mean_x;
  assign out_ch.mean_y          = res.mean_y;
  assign out_ch.mean_z          = res.mean_z;
  assign out_ch.no_valid_points = res.no_valid_points;

`ifndef SYNTHESIS
  // input is blocked while the means are being divided
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.cmd == pcmc_pkg::CMD_ACCUM) &&
     in_ch.last_point) |=> !in_ch.ready)
    else $error("input accepted right after last pass-one point");

  a_empty_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.result_kind == pcmc_pkg::KIND_REPORT) &&
     out_ch.no_valid_points) |->
    ((out_ch.mean_x == 0) && (out_ch.mean_y == 0) && (out_ch.mean_z == 0)))
    else $error("empty cloud report with nonzero means");

  a_point_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.result_kind == pcmc_pkg::KIND_POINT)) |->
    !out_ch.no_valid_points)
    else $error("centered point carries empty-cloud flag");

  a_report_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.result_kind == pcmc_pkg::KIND_REPORT)) |->
    (out_ch.out_last && (out_ch.out_x == 0)))
    else $error("report without last marker or with coordinates");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_point_cloud_mean_centering_core.sv
// ---------------------------------------------------------------------------
// tb_point_cloud_mean_centering_core
// Checks two-pass centroid subtraction against a cycle-free predictor: pass-one
// clouds with reports, pass-two centering, saturation, truncation and empty
// clouds, followed by random clouds with and then without random valid/ready gaps.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_point_cloud_mean_centering_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pcmc_pkg::*;

  localparam longint COORD_HI       = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_LO       = -COORD_HI - 1;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     TAIL_CYCLES    = 60;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               pv;
    logic               last;
  } point_t;

  logic clk;
  logic rst_n;

  pcmc_in_if  pts_ch ();
  pcmc_out_if res_ch ();

  point_cloud_mean_centering_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pts_ch),
    .out_ch (res_ch)
  );

  // predictor state
  logic [SUM_W-1:0]   sum_x, sum_y, sum_z;
  logic [CNT_W-1:0]   pts_counted;
  logic [COORD_W-1:0] centroid_x, centroid_y, centroid_z;

  res_t cloud_results_q[$];
  res_t head_res;
  int   mismatches;
  int   quiet_cycles;
  bit   src_idle_on;
  bit   sink_stall_on;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
    if (v > COORD_HI) return COORD_MAX;
    if (v < COORD_LO) return COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  // Advances the centering state by one point; returns 1 if it yields a result.
  function automatic bit center_cloud_point(input point_t p, output res_t r);
    r = '0;
    if (p.cmd == CMD_ACCUM) begin
      if (p.pv && pts_counted < CNT_LIMIT) begin
        sum_x = sum_x + {{(SUM_W-COORD_W){p.x[COORD_W-1]}}, p.x};
        sum_y = sum_y + {{(SUM_W-COORD_W){p.y[COORD_W-1]}}, p.y};
        sum_z = sum_z + {{(SUM_W-COORD_W){p.z[COORD_W-1]}}, p.z};
        pts_counted = pts_counted + 1'b1;
      end
      if (!p.last) return 0;
      r.no_valid_points = (pts_counted == 0);
      if (pts_counted == 0) begin
        centroid_x = '0;
        centroid_y = '0;
        centroid_z = '0;
      end else begin
        // signed longint division truncates toward zero
        centroid_x = clamp_coord(longint'($signed(sum_x)) / longint'(pts_counted));
        centroid_y = clamp_coord(longint'($signed(sum_y)) / longint'(pts_counted));
        centroid_z = clamp_coord(longint'($signed(sum_z)) / longint'(pts_counted));
      end
      sum_x = '0;
      sum_y = '0;
      sum_z = '0;
      pts_counted = '0;
      r.result_kind = KIND_REPORT;
    end else begin
      r.result_kind = KIND_POINT;
      if (p.pv) begin
        r.out_x = clamp_coord(longint'($signed(p.x)) - longint'($signed(centroid_x)));
        r.out_y = clamp_coord(longint'($signed(p.y)) - longint'($signed(centroid_y)));
        r.out_z = clamp_coord(longint'($signed(p.z)) - longint'($signed(centroid_z)));
      end else begin
        r.out_x = p.x;
        r.out_y = p.y;
        r.out_z = p.z;
      end
    end
    r.out_point_valid = p.pv;
    r.out_last        = p.last;
    r.mean_x          = centroid_x;
    r.mean_y          = centroid_y;
    r.mean_z          = centroid_z;
    return 1;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2, 3:    return COORD_W'($urandom_range(2000)) - COORD_W'(1000);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns ERROR: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [COORD_W-1:0] got,
                             input logic [COORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  task automatic send_point(input logic cmd, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                            input logic pv, input logic last);
    point_t p;
    res_t   r;
    p = '{cmd: cmd, x: x, y: y, z: z, pv: pv, last: last};
    @(negedge clk);
    while (src_idle_on && $urandom_range(99) < 10) begin
      pts_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pts_ch.valid       <= 1'b1;
    pts_ch.cmd         <= p.cmd;
    pts_ch.coord_x     <= p.x;
    pts_ch.coord_y     <= p.y;
    pts_ch.coord_z     <= p.z;
    pts_ch.point_valid <= p.pv;
    pts_ch.last_point  <= p.last;
    do @(posedge clk); while (!pts_ch.ready);
    if (center_cloud_point(p, r)) cloud_results_q.push_back(r);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    pts_ch.valid <= 1'b0;
    while (cloud_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_center_after_reset();
    // stored means are zero out of reset
    send_point(CMD_CENTER, COORD_MAX, COORD_MIN, 32'd1, 1'b1, 1'b0);
    send_point(CMD_CENTER, COORD_MIN, COORD_MAX, 32'hFFFF_FFFF, 1'b0, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_empty_cloud();
    send_point(CMD_ACCUM, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
    send_point(CMD_ACCUM, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b1);
    send_point(CMD_CENTER, 32'd123, -32'sd5, COORD_MIN, 1'b1, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_truncation();
    // -7/2 must give -3; the invalid last point is not summed
    send_point(CMD_ACCUM, -32'sd7, 32'd7, -32'sd5, 1'b1, 1'b0);
    send_point(CMD_ACCUM, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0);
    send_point(CMD_ACCUM, 32'd100, 32'd100, 32'd100, 1'b0, 1'b1);
    send_point(CMD_CENTER, -32'sd3, 32'd3, 32'd0, 1'b1, 1'b0);
    send_point(CMD_CENTER, 32'hDEAD_BEEF, 32'h1234_5678, 32'd9, 1'b0, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_saturation();
    // valid last point is summed; centered values clamp at both ends
    send_point(CMD_ACCUM, COORD_MAX, COORD_MIN, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_point(CMD_ACCUM, COORD_MAX, COORD_MIN, 32'd0, 1'b1, 1'b0);
    send_point(CMD_ACCUM, COORD_MAX, COORD_MIN, 32'd0, 1'b1, 1'b1);
    send_point(CMD_CENTER, COORD_MIN, COORD_MAX, 32'd0, 1'b1, 1'b0);
    send_point(CMD_CENTER, COORD_MAX, COORD_MIN, 32'd5, 1'b1, 1'b0);
    send_point(CMD_CENTER, COORD_MIN, COORD_MAX, 32'd1, 1'b0, 1'b1);
    wait_results_drained();
  endtask

  task automatic run_random_clouds(input int n_items);
    int sent;
    int npts;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        npts = $urandom_range(16, 1);
        for (int i = 0; i < npts; i++)
          send_point(CMD_ACCUM, rand_coord(), rand_coord(), rand_coord(),
                     $urandom_range(99) < 85, i == npts - 1);
        for (int i = 0; i < npts; i++)
          send_point(CMD_CENTER, rand_coord(), rand_coord(), rand_coord(),
                     $urandom_range(99) < 85, i == npts - 1);
        sent += 2 * npts;
      end else begin
        // stray points: either command, random flags
        npts = $urandom_range(4, 1);
        for (int i = 0; i < npts; i++)
          send_point(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
                     1'($urandom_range(1)), $urandom_range(3) == 0);
        sent += npts;
      end
    end
    wait_results_drained();
  endtask

  task automatic test_random_clouds();
    run_random_clouds(450);
  endtask

  task automatic test_burst_no_idle();
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    run_random_clouds(150);
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  always @(negedge clk)
    res_ch.ready <= !(sink_stall_on && $urandom_range(99) < 10);

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (cloud_results_q.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        head_res = cloud_results_q.pop_front();
        check_field("result_kind", COORD_W'(res_ch.result_kind),
                    COORD_W'(head_res.result_kind));
        check_field("out_x", res_ch.out_x, head_res.out_x);
        check_field("out_y", res_ch.out_y, head_res.out_y);
        check_field("out_z", res_ch.out_z, head_res.out_z);
        check_field("out_point_valid", COORD_W'(res_ch.out_point_valid),
                    COORD_W'(head_res.out_point_valid));
        check_field("out_last", COORD_W'(res_ch.out_last), COORD_W'(head_res.out_last));
        check_field("mean_x", res_ch.mean_x, head_res.mean_x);
        check_field("mean_y", res_ch.mean_y, head_res.mean_y);
        check_field("mean_z", res_ch.mean_z, head_res.mean_z);
        check_field("no_valid_points", COORD_W'(res_ch.no_valid_points),
                    COORD_W'(head_res.no_valid_points));
      end
    end
  end

  always @(posedge clk) begin
    if ((pts_ch.valid && pts_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n              = 1'b0;
    pts_ch.valid       = 1'b0;
    pts_ch.cmd         = CMD_ACCUM;
    pts_ch.coord_x     = '0;
    pts_ch.coord_y     = '0;
    pts_ch.coord_z     = '0;
    pts_ch.point_valid = 1'b0;
    pts_ch.last_point  = 1'b0;
    res_ch.ready       = 1'b0;
    sum_x              = '0;
    sum_y              = '0;
    sum_z              = '0;
    pts_counted        = '0;
    centroid_x         = '0;
    centroid_y         = '0;
    centroid_z         = '0;
    mismatches         = 0;
    quiet_cycles       = 0;
    src_idle_on        = 1'b1;
    sink_stall_on      = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_center_after_reset();
    test_empty_cloud();
    test_truncation();
    test_saturation();
    test_random_clouds();
    test_burst_no_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (cloud_results_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", cloud_results_q.size()));
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
src/pcmc_pkg.sv
src/pcmc_in_if.sv
src/pcmc_out_if.sv
src/pcmc_ctrl.sv
src/pcmc_dp.sv
src/point_cloud_mean_centering_core.sv
tb/sv/tb_point_cloud_mean_centering_core.sv
